>>> src/clq_pkg.sv
// Shared types and codes for the circular queue link manager.
package clq_pkg;

  localparam int unsigned NodesDefault = 64;

  localparam int unsigned ModeW  = 2;
  localparam int unsigned ElemW  = 6;
  localparam int unsigned TotalW = 7;

  localparam logic [ModeW-1:0] MODE_APPEND = 2'd0;
  localparam logic [ModeW-1:0] MODE_REMOVE = 2'd1;
  localparam logic [ModeW-1:0] MODE_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LINKED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_ABSENT = 2'd3
  } status_e;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [ElemW-1:0] elem_index;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [TotalW-1:0] entry_total;
    logic [ElemW-1:0]  head_slot;
    logic              head_valid;
  } rsp_t;

endpackage

>>> src/circular_queue_link_manager.sv
// Circular doubly linked queue over a pool of slots, with link tables in RAM.
// The next-link RAM also carries the linked flag of each slot, so after reset the block runs a
// clearing pass over every slot with busy_o high before it takes its first command. Each
// command returns exactly one result, strobed by rsp_valid_o for one cycle; the receiver
// cannot stall it. A query, a slot beyond the pool and a removal from an empty queue finish in
// IDLE. Every other command first reads the slot's flag and links: a refused command, the first
// append and the removal of the last element finish in APP_LOOK or REM_LOOK. An append to a
// non-empty queue reads the tail, writes the new element's links in APP_LOOK and then the tail's
// and head's links in APP_LINK, since each link RAM has a single write port. A removal of one of
// several elements reads both neighbors, rewrites them in REM_LOOK and clears the flag of the
// removed slot in REM_CLR. busy_o is high while a command is still in work; the next command
// may be issued in the cycle its result is shown.
module circular_queue_link_manager
#(
  parameter int unsigned NODES = clq_pkg::NodesDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  clq_pkg::req_t req_i,
  output logic          busy_o,
  output logic          rsp_valid_o,
  output clq_pkg::rsp_t rsp_o
);
  import clq_pkg::*;

  localparam int unsigned IdxW  = $clog2(NODES);
  localparam int unsigned CntW  = $clog2(NODES + 1);
  localparam int unsigned NextW = IdxW + 1;

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    APP_LOOK,
    APP_LINK,
    REM_LOOK,
    REM_CLR
  } state_e;

  state_e            state_q, state_d;
  logic [IdxW-1:0]   clr_q, clr_d;
  logic [IdxW-1:0]   elem_q, elem_d;
  logic [IdxW-1:0]   tail_q, tail_d;
  logic [IdxW-1:0]   head_q, head_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              rsp_valid_q, rsp_valid_d;
  rsp_t              rsp_q, rsp_d;

  logic              accept;
  logic [IdxW-1:0]   elem_in;
  logic              in_range;
  logic              slot_linked;
  logic [IdxW-1:0]   next_slot;
  logic              finish;
  status_e           status_d;

  logic              next_we, prev_we;
  logic [IdxW-1:0]   next_waddr, next_raddr;
  logic [NextW-1:0]  next_wdata, next_rdata;
  logic [IdxW-1:0]   prev_waddr, prev_wdata, prev_raddr, prev_rdata;

  clq_ram #(.Width(NextW), .Depth(NODES)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (next_raddr),
    .rdata_o (next_rdata)
  );

  clq_ram #(.Width(IdxW), .Depth(NODES)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (prev_raddr),
    .rdata_o (prev_rdata)
  );

  assign busy_o      = (state_q != IDLE);
  assign accept      = start_i && !busy_o;
  assign elem_in     = IdxW'(req_i.elem_index);
  assign in_range    = (32'(req_i.elem_index) < 32'(NODES));
  // The top bit of a next-link word is the linked flag of that slot.
  assign slot_linked = next_rdata[IdxW];
  assign next_slot   = next_rdata[IdxW-1:0];

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    elem_d     = elem_q;
    tail_d     = tail_q;
    head_d     = head_q;
    count_d    = count_q;
    finish     = 1'b0;
    status_d   = ST_OK;
    next_we    = 1'b0;
    next_waddr = '0;
    next_wdata = '0;
    next_raddr = '0;
    prev_we    = 1'b0;
    prev_waddr = '0;
    prev_wdata = '0;
    prev_raddr = '0;

    case (state_q)
      CLEAR: begin
        next_we    = 1'b1;
        next_waddr = clr_q;
        clr_d      = clr_q + IdxW'(1);
        if (clr_q == IdxW'(NODES - 1)) begin
          state_d = IDLE;
        end
      end
      IDLE: begin
        if (accept) begin
          elem_d = elem_in;
          case (req_i.mode)
            MODE_APPEND: begin
              if (!in_range) begin
                status_d = ST_ABSENT;
                finish   = 1'b1;
              end else begin
                // The tail is the predecessor of the head.
                next_raddr = elem_in;
                prev_raddr = head_q;
                state_d    = APP_LOOK;
              end
            end
            MODE_REMOVE: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                finish   = 1'b1;
              end else if (!in_range) begin
                status_d = ST_ABSENT;
                finish   = 1'b1;
              end else begin
                next_raddr = elem_in;
                prev_raddr = elem_in;
                state_d    = REM_LOOK;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      APP_LOOK: begin
        if (slot_linked) begin
          status_d = ST_LINKED;
          finish   = 1'b1;
          state_d  = IDLE;
        end else if (count_q == '0) begin
          next_we    = 1'b1;
          next_waddr = elem_q;
          next_wdata = {1'b1, elem_q};
          prev_we    = 1'b1;
          prev_waddr = elem_q;
          prev_wdata = elem_q;
          head_d     = elem_q;
          count_d    = count_q + CntW'(1);
          finish     = 1'b1;
          state_d    = IDLE;
        end else begin
          tail_d     = prev_rdata;
          next_we    = 1'b1;
          next_waddr = elem_q;
          next_wdata = {1'b1, head_q};
          prev_we    = 1'b1;
          prev_waddr = elem_q;
          prev_wdata = prev_rdata;
          state_d    = APP_LINK;
        end
      end
      APP_LINK: begin
        next_we    = 1'b1;
        next_waddr = tail_q;
        next_wdata = {1'b1, elem_q};
        prev_we    = 1'b1;
        prev_waddr = head_q;
        prev_wdata = elem_q;
        count_d    = count_q + CntW'(1);
        finish     = 1'b1;
        state_d    = IDLE;
      end
      REM_LOOK: begin
        if (!slot_linked) begin
          status_d = ST_ABSENT;
          finish   = 1'b1;
          state_d  = IDLE;
        end else if (count_q == CntW'(1)) begin
          next_we    = 1'b1;
          next_waddr = elem_q;
          head_d     = '0;
          count_d    = count_q - CntW'(1);
          finish     = 1'b1;
          state_d    = IDLE;
        end else begin
          // The read data holds the predecessor (prev) and successor (next) of the element.
          next_we    = 1'b1;
          next_waddr = prev_rdata;
          next_wdata = {1'b1, next_slot};
          prev_we    = 1'b1;
          prev_waddr = next_slot;
          prev_wdata = prev_rdata;
          if (elem_q == head_q) begin
            head_d = next_slot;
          end
          state_d    = REM_CLR;
        end
      end
      REM_CLR: begin
        next_we    = 1'b1;
        next_waddr = elem_q;
        count_d    = count_q - CntW'(1);
        finish     = 1'b1;
        state_d    = IDLE;
      end
      default: begin
        state_d = IDLE;
      end
    endcase

    rsp_valid_d       = finish;
    rsp_d.status      = status_d;
    rsp_d.entry_total = TotalW'(count_d);
    rsp_d.head_valid  = (count_d != '0);
    rsp_d.head_slot   = (count_d != '0) ? ElemW'(head_d) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CLEAR;
      clr_q       <= '0;
      elem_q      <= '0;
      tail_q      <= '0;
      head_q      <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      elem_q      <= elem_d;
      tail_q      <= tail_d;
      head_q      <= head_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
      if (rsp_valid_d) begin
        rsp_q <= rsp_d;
      end
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

>>> src/clq_ram.sv
// Generic single write port, single read port RAM with a registered read.
module clq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/clq_checker.sv
// Port-level checks for the circular queue link manager, bound to the top level.
module clq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input logic          rsp_valid_o,
  input clq_pkg::rsp_t rsp_o
);
  import clq_pkg::*;

  // A result is only shown once the command is finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !busy_o)
    else $error("result shown while busy");

  // Every accepted command either keeps the block busy or returns its result next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || rsp_valid_o))
    else $error("accepted command dropped");

  // A result follows either an accepted command or the end of a busy period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> ($past(busy_o) || $past(start_i)))
    else $error("result without a command");

  // The head is reported valid exactly when the queue holds elements.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.head_valid == (rsp_o.entry_total != '0)))
    else $error("head valid disagrees with entry total");

endmodule

bind circular_queue_link_manager clq_checker u_clq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .rsp_valid_o (rsp_valid_o),
  .rsp_o       (rsp_o)
);
